FILE: hdl/tld_pkg.sv
package tld_pkg;

  localparam int KeyRingDepth  = 512;
  localparam int EditLineDepth = 256;
  localparam int LineFifoDepth = 4096;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_CHAR  = 2'd1,
    ECHO_ERASE = 2'd2,
    ECHO_INTR  = 2'd3
  } echo_e;

  typedef enum logic [2:0] {
    REG_COOKED = 3'd0,
    REG_ECHO   = 3'd1,
    REG_SIGNAL = 3'd2,
    REG_CRNL   = 3'd3,
    REG_INTR   = 3'd4
  } reg_e;

  localparam logic [7:0] ChEof      = 8'h04;
  localparam logic [7:0] ChKillLine = 8'h15;
  localparam logic [7:0] ChKillWord = 8'h17;
  localparam logic [7:0] ChDel      = 8'h7F;
  localparam logic [7:0] ChBs       = 8'h08;
  localparam logic [7:0] ChNl       = 8'h0A;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChSpace    = 8'h20;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture command and byte
    logic key_wr;     // push byte into key ring
    logic fifo_nl;    // push NL or EOF into line fifo
    logic edit_push;  // append to edit line
    logic edit_clr;   // edit length to zero
    logic edit_dec;   // edit length minus one
    logic rd_issue;   // issue edit-line read at scan index
    logic copy_push;  // push read edit byte into fifo
    logic scan_init;  // scan index := edit length (kill word) or 0 (copy)
    logic scan_step;  // advance scan index
    logic pop;        // read pop
    logic flush;
    logic intr;       // interrupt cancels the line
    logic kw_done;    // kill word scan finished
    logic done;       // present result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [7:0] ch;       // converted byte
    logic       edit_empty;
    logic       edit_full;
    logic       scan_end;  // copy index reached length / kill index at zero
    logic       rd_space;  // registered edit byte is a space
  } sts_t;

endpackage

FILE: hdl/tld_ctrl.sv
module tld_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    command_i,
  input  logic          cooked_i,
  input  logic          signal_i,
  input  logic [7:0]    intr_char_i,
  input  tld_pkg::sts_t sts_i,
  output tld_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          kill_word_o
);
  import tld_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_COPY_RD, S_COPY_WR, S_KW_RD, S_KW_CHK, S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cmd_q;
  logic       nl_after_q, nl_after_d;  // Enter queues NL after the copy
  logic       kw_word_q, kw_word_d;    // kill word past the spaces

  always_comb begin
    ctl_o      = '0;
    state_d    = state_q;
    nl_after_d = nl_after_q;
    kw_word_d  = kw_word_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (cmd_q)
          CMD_READ:  ctl_o.pop = 1'b1;
          CMD_FLUSH: ctl_o.flush = 1'b1;
          CMD_KEY: begin
            if (!cooked_i) begin
              ctl_o.key_wr = 1'b1;
            end else if (signal_i && sts_i.ch == intr_char_i) begin
              ctl_o.edit_clr = 1'b1;
              ctl_o.fifo_nl  = 1'b1;
              ctl_o.key_wr   = 1'b1;
              ctl_o.intr     = 1'b1;
            end else if (sts_i.ch == ChEof) begin
              ctl_o.key_wr = 1'b1;
              if (sts_i.edit_empty) begin
                ctl_o.fifo_nl = 1'b1;
              end else begin
                ctl_o.scan_init = 1'b1;
                nl_after_d      = 1'b0;
                state_d         = S_COPY_RD;
              end
            end else if (sts_i.ch == ChKillLine) begin
              ctl_o.edit_clr = 1'b1;
            end else if (sts_i.ch == ChKillWord) begin
              ctl_o.scan_init = 1'b1;
              kw_word_d       = 1'b0;
              state_d         = S_KW_RD;
            end else if (sts_i.ch == ChDel || sts_i.ch == ChBs) begin
              ctl_o.key_wr   = 1'b1;
              ctl_o.edit_dec = !sts_i.edit_empty;
            end else if (sts_i.ch == ChNl) begin
              ctl_o.key_wr    = 1'b1;
              ctl_o.scan_init = 1'b1;
              nl_after_d      = 1'b1;
              state_d         = S_COPY_RD;
            end else begin
              ctl_o.key_wr    = 1'b1;
              ctl_o.edit_push = sts_i.ch >= ChSpace && sts_i.ch < ChDel
                                && !sts_i.edit_full;
            end
          end
          default: ;
        endcase
      end
      S_COPY_RD: begin
        if (sts_i.scan_end) begin
          ctl_o.edit_clr = 1'b1;
          ctl_o.fifo_nl  = nl_after_q;
          state_d        = S_DONE;
        end else begin
          ctl_o.rd_issue = 1'b1;
          state_d        = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        ctl_o.copy_push = 1'b1;
        ctl_o.scan_step = 1'b1;
        state_d         = S_COPY_RD;
      end
      S_KW_RD: begin
        if (sts_i.scan_end) begin
          ctl_o.kw_done = 1'b1;
          state_d       = S_DONE;
        end else begin
          ctl_o.rd_issue = 1'b1;
          state_d        = S_KW_CHK;
        end
      end
      S_KW_CHK: begin
        if (sts_i.rd_space && kw_word_q) begin
          ctl_o.kw_done = 1'b1;
          state_d       = S_DONE;
        end else begin
          kw_word_d       = !sts_i.rd_space;
          ctl_o.scan_step = 1'b1;
          state_d         = S_KW_RD;
        end
      end
      S_DONE: begin
        ctl_o.done = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= CMD_NOP;
      nl_after_q <= 1'b0;
      kw_word_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      nl_after_q <= nl_after_d;
      kw_word_q  <= kw_word_d;
      if (ctl_o.latch) cmd_q <= command_i;
    end
  end

  assign busy_o      = state_q != S_IDLE;
  assign kill_word_o = state_q == S_KW_RD || state_q == S_KW_CHK;

  a_copy_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COPY_WR |-> $past(state_q) == S_COPY_RD)
    else $error("copy write without read");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> state_q == S_IDLE)
    else $error("done not single cycle");
  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.pop && (ctl_o.key_wr || ctl_o.flush)))
    else $error("pop together with push or flush");
endmodule

FILE: hdl/tld_datapath.sv
module tld_datapath #(
  parameter int KeyDepth  = tld_pkg::KeyRingDepth,
  parameter int EditDepth = tld_pkg::EditLineDepth,
  parameter int FifoDepth = tld_pkg::LineFifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tld_pkg::ctl_t ctl_i,
  input  logic          kill_word_i,
  input  logic [7:0]    key_char_i,
  input  logic          cooked_i,
  input  logic          echo_i,
  input  logic          crnl_i,
  output tld_pkg::sts_t sts_o,
  output logic          done_o,
  output logic [1:0]    echo_kind_o,
  output logic [7:0]    echo_char_o,
  output logic [7:0]    erase_count_o,
  output logic          read_valid_o,
  output logic [7:0]    read_data_o,
  output logic [11:0]   bytes_available_o
);
  import tld_pkg::*;

  localparam int KW = $clog2(KeyDepth);
  localparam int EW = $clog2(EditDepth);
  localparam int EL = $clog2(EditDepth + 1);
  localparam int FW = $clog2(FifoDepth);
  localparam logic [KW-1:0] KeyLast  = KW'(KeyDepth - 1);
  localparam logic [FW-1:0] FifoLast = FW'(FifoDepth - 1);
  localparam logic [EL-1:0] EditMax  = EL'(EditDepth - 1);

  logic [7:0] key_mem  [KeyDepth];
  logic [7:0] edit_mem [EditDepth];
  logic [7:0] fifo_mem [FifoDepth];

  logic [KW-1:0] kwp_q, krp_q;
  logic [FW-1:0] fwp_q, frp_q;
  logic [EL-1:0] elen_q, scan_q, kw_start_q;
  logic [7:0]    ch_q, erd_q, frd_q, krd_q;
  logic          pop_k_q, pop_f_q, done_q;
  logic [1:0]    kind_q;
  logic [7:0]    echr_q, erase_q;

  logic [KW-1:0] kwp_nx, krp_nx;
  logic [FW-1:0] fwp_nx, frp_nx;
  logic          key_full, fifo_full, kring_empty, fifo_empty;
  logic          fifo_push;
  logic [7:0]    fifo_byte;
  logic [KW-1:0] key_lvl;
  logic [FW-1:0] fifo_lvl;
  logic [31:0]   lvl;
  logic [EL-1:0] erased;
  logic [EL-1:0] scan_idx;

  assign kwp_nx = (kwp_q == KeyLast) ? '0 : kwp_q + 1'b1;
  assign krp_nx = (krp_q == KeyLast) ? '0 : krp_q + 1'b1;
  assign fwp_nx = (fwp_q == FifoLast) ? '0 : fwp_q + 1'b1;
  assign frp_nx = (frp_q == FifoLast) ? '0 : frp_q + 1'b1;
  assign key_full    = kwp_nx == krp_q;
  assign fifo_full   = fwp_nx == frp_q;
  assign kring_empty = kwp_q == krp_q;
  assign fifo_empty  = fwp_q == frp_q;

  assign fifo_push = ctl_i.fifo_nl || ctl_i.copy_push;
  assign fifo_byte = ctl_i.copy_push ? erd_q
                   : (ctl_i.intr || ch_q != ChEof) ? ChNl : ChEof;
  // EOF on empty line queues 0x04; interrupt and Enter queue NL
  assign scan_idx = kill_word_i ? scan_q - 1'b1 : scan_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.key_wr && !key_full) key_mem[kwp_q] <= ch_q;
    if (fifo_push && !fifo_full)   fifo_mem[fwp_q] <= fifo_byte;
    if (ctl_i.edit_push)           edit_mem[elen_q[EW-1:0]] <= ch_q;
    if (ctl_i.rd_issue)            erd_q <= edit_mem[scan_idx[EW-1:0]];
    // read data held until the next pop
    if (ctl_i.pop)                 krd_q <= key_mem[krp_q];
    if (ctl_i.pop)                 frd_q <= fifo_mem[frp_q];
    if (ctl_i.latch) ch_q <= (crnl_i && key_char_i == ChCr) ? ChNl : key_char_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kwp_q <= '0; krp_q <= '0; fwp_q <= '0; frp_q <= '0;
      elen_q <= '0; scan_q <= '0; kw_start_q <= '0;
      pop_k_q <= 1'b0; pop_f_q <= 1'b0; done_q <= 1'b0;
      kind_q <= ECHO_NONE; echr_q <= '0; erase_q <= '0;
    end else begin
      done_q <= ctl_i.done;
      if (ctl_i.latch) begin
        kind_q  <= ECHO_NONE;
        echr_q  <= '0;
        erase_q <= '0;
        pop_k_q <= 1'b0;
        pop_f_q <= 1'b0;
      end
      if (ctl_i.flush) begin
        kwp_q <= '0; krp_q <= '0; fwp_q <= '0; frp_q <= '0; elen_q <= '0;
      end
      if (ctl_i.key_wr && !key_full) kwp_q <= kwp_nx;
      if (fifo_push && !fifo_full)   fwp_q <= fwp_nx;
      if (ctl_i.pop) begin
        if (cooked_i) begin
          pop_f_q <= !fifo_empty;
          if (!fifo_empty) frp_q <= frp_nx;
        end else begin
          pop_k_q <= !kring_empty;
          if (!kring_empty) krp_q <= krp_nx;
        end
      end
      if (ctl_i.scan_init) begin
        scan_q     <= (ch_q == ChKillWord) ? elen_q : '0;
        kw_start_q <= elen_q;
      end
      if (ctl_i.scan_step) scan_q <= kill_word_i ? scan_q - 1'b1 : scan_q + 1'b1;
      if (ctl_i.edit_push) elen_q <= elen_q + 1'b1;
      if (ctl_i.edit_dec)  elen_q <= elen_q - 1'b1;
      if (ctl_i.edit_clr && !ctl_i.flush) elen_q <= '0;
      if (ctl_i.kw_done)   elen_q <= scan_q;
      // echo
      if (echo_i) begin
        if (ctl_i.edit_push) begin
          kind_q <= ECHO_CHAR; echr_q <= ch_q;
        end
        if (ctl_i.fifo_nl && !ctl_i.intr && ch_q == ChNl) begin
          kind_q <= ECHO_CHAR; echr_q <= ChNl;
        end
        if (ctl_i.edit_dec) begin
          kind_q <= ECHO_ERASE; erase_q <= 8'd1;
        end
        if (ctl_i.edit_clr && ch_q == ChKillLine && elen_q != '0) begin
          kind_q <= ECHO_ERASE; erase_q <= (elen_q > EL'(255)) ? 8'hFF : 8'(elen_q);
        end
        if (ctl_i.intr) begin
          kind_q <= ECHO_INTR;
        end
        if (ctl_i.kw_done && erased != '0) begin
          kind_q  <= ECHO_ERASE;
          erase_q <= (erased > EL'(255)) ? 8'hFF : 8'(erased);
        end
      end
    end
  end

  assign erased = kw_start_q - scan_q;

  // levels wrap at the store depth
  assign key_lvl  = (kwp_q >= krp_q) ? kwp_q - krp_q : kwp_q - krp_q + KW'(KeyDepth);
  assign fifo_lvl = (fwp_q >= frp_q) ? fwp_q - frp_q : fwp_q - frp_q + FW'(FifoDepth);

  assign sts_o.ch         = ch_q;
  assign sts_o.edit_empty = elen_q == '0;
  assign sts_o.edit_full  = elen_q >= EditMax;
  assign sts_o.scan_end   = kill_word_i ? scan_q == '0 : scan_q == elen_q;
  assign sts_o.rd_space   = erd_q == ChSpace;

  assign done_o        = done_q;
  assign echo_kind_o   = kind_q;
  assign echo_char_o   = echr_q;
  assign erase_count_o = erase_q;
  assign read_valid_o  = pop_k_q | pop_f_q;
  assign read_data_o   = pop_k_q ? krd_q : (pop_f_q ? frd_q : 8'h00);
  assign lvl               = cooked_i ? 32'(fifo_lvl) : 32'(key_lvl);
  assign bytes_available_o = (lvl > 32'd4095) ? 12'hFFF : lvl[11:0];

  a_edit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elen_q <= EditMax) else $error("edit line overrun");
  a_pop_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_k_q && pop_f_q)) else $error("pop from both stores");
  a_erase_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && kind_q == ECHO_ERASE |-> erase_q != 8'h00)
    else $error("empty erase echo");
endmodule

FILE: hdl/tty_line_discipline.sv
// Channel | Dir | Signals
// --------+-----+-------------------------------------------------
// command | in  | start, busy, command_i, key_char_i
// result  | out | done_o, echo_kind_o, echo_char_o, erase_count_o,
//         |     | read_valid_o, read_data_o, bytes_available_o
// config  | in  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
//
// One item at a time: start accepted while busy is low, done_o pulses
// one cycle with the result. Read, flush, raw and simple keys pass only the
// decode and done states; the next item may be taken in the done_o
// cycle. Enter/EOF copy the edit line one byte at a time (read, then write),
// kill word scans back one byte at a time (read, then check).
// Config is accepted only while busy is low.
// Reset clears pointers, length and control registers; memories and byte data registers are not cleared.
// The receiver cannot stall: done_o is a one-cycle strobe.
module tty_line_discipline #(
  parameter int KEY_RING_DEPTH  = tld_pkg::KeyRingDepth,
  parameter int EDIT_LINE_DEPTH = tld_pkg::EditLineDepth,
  parameter int LINE_FIFO_DEPTH = tld_pkg::LineFifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [7:0]  key_char_i,
  output logic        done_o,
  output logic [1:0]  echo_kind_o,
  output logic [7:0]  echo_char_o,
  output logic [7:0]  erase_count_o,
  output logic        read_valid_o,
  output logic [7:0]  read_data_o,
  output logic [11:0] bytes_available_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import tld_pkg::*;

  logic       cooked_q, echo_q, signal_q, crnl_q;
  logic [7:0] intr_q;
  ctl_t       ctl;
  sts_t       sts;
  logic       kill_word;

  assign cfg_ready_o = !busy;

  // config registers, written only while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooked_q <= 1'b1;
      echo_q   <= 1'b1;
      signal_q <= 1'b1;
      crnl_q   <= 1'b1;
      intr_q   <= 8'h03;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COOKED: cooked_q <= cfg_data_i[0];
        REG_ECHO:   echo_q   <= cfg_data_i[0];
        REG_SIGNAL: signal_q <= cfg_data_i[0];
        REG_CRNL:   crnl_q   <= cfg_data_i[0];
        REG_INTR:   intr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tld_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i     (start),
    .command_i,
    .cooked_i    (cooked_q),
    .signal_i    (signal_q),
    .intr_char_i (intr_q),
    .sts_i       (sts),
    .ctl_o       (ctl),
    .busy_o      (busy),
    .kill_word_o (kill_word)
  );

  tld_datapath #(
    .KeyDepth  (KEY_RING_DEPTH),
    .EditDepth (EDIT_LINE_DEPTH),
    .FifoDepth (LINE_FIFO_DEPTH)
  ) u_dp (
    .clk_i, .rst_ni,
    .ctl_i       (ctl),
    .kill_word_i (kill_word),
    .key_char_i,
    .cooked_i    (cooked_q),
    .echo_i      (echo_q),
    .crnl_i      (crnl_q),
    .sts_o       (sts),
    .done_o,
    .echo_kind_o,
    .echo_char_o,
    .erase_count_o,
    .read_valid_o,
    .read_data_o,
    .bytes_available_o
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item not taken");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done while busy");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("done without item");
endmodule

FILE: tb/tb_tty_line_discipline.sv
module tb_tty_line_discipline;
  timeunit 1ns;
  timeprecision 1ps;

  import tld_pkg::*;

  // One result of the block, field by field at the port widths.
  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [7:0]  erase;
    logic        rv;
    logic [7:0]  rd;
    logic [11:0] avail;
  } tty_result_t;

  // Line discipline predictor plus the queue of expected results.
  class tty_scoreboard;
    // config copy
    bit         cooked = 1'b1;
    bit         echo_en = 1'b1;
    bit         sig_en = 1'b1;
    bit         crnl = 1'b1;
    logic [7:0] intr_ch = 8'h03;
    // stores
    logic [7:0] keys[KeyRingDepth];
    int         key_wr, key_rd;
    logic [7:0] line[EditLineDepth];
    int         edit_cnt;
    logic [7:0] lines[LineFifoDepth];
    int         lq_wr, lq_rd;
    tty_result_t pending_q[$];
    int         errors;

    function void set_reg(reg_e idx, logic [7:0] val);
      case (idx)
        REG_COOKED: cooked = val[0];
        REG_ECHO:   echo_en = val[0];
        REG_SIGNAL: sig_en = val[0];
        REG_CRNL:   crnl = val[0];
        REG_INTR:   intr_ch = val;
        default: ;
      endcase
    endfunction

    function int next_ptr(int p, int depth);
      return (p + 1 >= depth) ? 0 : p + 1;
    endfunction

    // Full rings drop the byte.
    function void ring_put(logic [7:0] b);
      if (next_ptr(key_wr, KeyRingDepth) != key_rd) begin
        keys[key_wr] = b;
        key_wr = next_ptr(key_wr, KeyRingDepth);
      end
    endfunction

    function void queue_push(logic [7:0] b);
      if (next_ptr(lq_wr, LineFifoDepth) != lq_rd) begin
        lines[lq_wr] = b;
        lq_wr = next_ptr(lq_wr, LineFifoDepth);
      end
    endfunction

    function void commit_line();
      for (int i = 0; i < edit_cnt; i++) queue_push(line[i]);
      edit_cnt = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // Accepted input item: work out the result it must cause.
    function void note_item(cmd_e cmd, logic [7:0] c_in);
      tty_result_t r;
      logic [7:0]  c;
      int          erase;
      int          first;
      r = '{kind: ECHO_NONE, ch: 8'h00, erase: 8'h00, rv: 1'b0, rd: 8'h00, avail: 12'h000};
      c = c_in;
      erase = 0;
      if (cmd == CMD_KEY) begin
        if (crnl && c == ChCr) c = ChNl;
        if (!cooked) begin
          ring_put(c);
        end else if (sig_en && c == intr_ch) begin
          edit_cnt = 0;
          queue_push(ChNl);
          ring_put(c);
          r.kind = ECHO_INTR;
        end else if (c == ChEof) begin
          if (edit_cnt == 0) queue_push(ChEof);
          else commit_line();
          ring_put(c);
        end else if (c == ChKillLine) begin
          erase = edit_cnt;
          edit_cnt = 0;
          r.kind = ECHO_ERASE;
        end else if (c == ChKillWord) begin
          first = edit_cnt;
          while (edit_cnt > 0 && line[edit_cnt-1] == ChSpace) edit_cnt--;
          while (edit_cnt > 0 && line[edit_cnt-1] != ChSpace) edit_cnt--;
          erase = first - edit_cnt;
          r.kind = ECHO_ERASE;
        end else if (c == ChDel || c == ChBs) begin
          if (edit_cnt > 0) begin
            edit_cnt--;
            erase = 1;
            r.kind = ECHO_ERASE;
          end
          ring_put(c);
        end else if (c == ChNl) begin
          commit_line();
          queue_push(ChNl);
          ring_put(ChNl);
          r.kind = ECHO_CHAR;
          r.ch = ChNl;
        end else begin
          // printable bytes are stored while the line has room
          if (c >= ChSpace && c < ChDel && edit_cnt < EditLineDepth - 1) begin
            line[edit_cnt] = c;
            edit_cnt++;
            r.kind = ECHO_CHAR;
            r.ch = c;
          end
          ring_put(c);
        end
        if (!echo_en || (r.kind == ECHO_ERASE && erase == 0)) begin
          r.kind = ECHO_NONE;
          r.ch = 8'h00;
          erase = 0;
        end
        r.erase = (erase > 255) ? 8'hFF : erase[7:0];
      end else if (cmd == CMD_READ) begin
        if (cooked && lq_wr != lq_rd) begin
          r.rv = 1'b1;
          r.rd = lines[lq_rd];
          lq_rd = next_ptr(lq_rd, LineFifoDepth);
        end else if (!cooked && key_wr != key_rd) begin
          r.rv = 1'b1;
          r.rd = keys[key_rd];
          key_rd = next_ptr(key_rd, KeyRingDepth);
        end
      end else if (cmd == CMD_FLUSH) begin
        key_wr = 0; key_rd = 0; lq_wr = 0; lq_rd = 0; edit_cnt = 0;
      end
      if (cooked) r.avail = 12'((lq_wr + LineFifoDepth - lq_rd) % LineFifoDepth);
      else        r.avail = 12'((key_wr + KeyRingDepth - key_rd) % KeyRingDepth);
      pending_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [11:0] got, logic [11:0] want);
      $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
      errors++;
    endtask

    task check_result(tty_result_t got);
      tty_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", got.avail, 12'h000);
      end else begin
        want = pending_q.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("echo_kind", 12'(got.kind), 12'(want.kind));
        if (got.ch !== want.ch)
          report_mismatch("echo_char", 12'(got.ch), 12'(want.ch));
        if (got.erase !== want.erase)
          report_mismatch("erase_count", 12'(got.erase), 12'(want.erase));
        if (got.rv !== want.rv)
          report_mismatch("read_valid", 12'(got.rv), 12'(want.rv));
        if (got.rd !== want.rd)
          report_mismatch("read_data", 12'(got.rd), 12'(want.rd));
        if (got.avail !== want.avail)
          report_mismatch("bytes_available", got.avail, want.avail);
      end
    endtask
  endclass

  localparam int CycleLimit = 6_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = CMD_NOP;
  logic [7:0]  key_char_i = 8'h00;
  logic        done_o;
  logic [1:0]  echo_kind_o;
  logic [7:0]  echo_char_o;
  logic [7:0]  erase_count_o;
  logic        read_valid_o;
  logic [7:0]  read_data_o;
  logic [11:0] bytes_available_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = REG_COOKED;
  logic [7:0]  cfg_data_i = 8'h00;

  tty_scoreboard sb = new();
  bit            steady;      // no idling in this stretch
  logic [7:0]    cur_intr = 8'h03;
  int            cycles;

  tty_line_discipline uut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .key_char_i,
    .done_o, .echo_kind_o, .echo_char_o, .erase_count_o,
    .read_valid_o, .read_data_o, .bytes_available_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Results are strobes: take every one at the edge that ends its cycle.
  always @(posedge clk_i) begin
    tty_result_t got;
    if (rst_ni && done_o) begin
      got = '{kind: echo_kind_o, ch: echo_char_o, erase: erase_count_o,
              rv: read_valid_o, rd: read_data_o, avail: bytes_available_o};
      sb.check_result(got);
    end
  end

  // One command item; start stays high into the next call unless it idles.
  task send(cmd_e cmd, logic [7:0] ch);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 18) begin
      start <= 1'b0;
      command_i <= 2'($urandom);
      key_char_i <= 8'($urandom);
      @(negedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    key_char_i <= ch;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_item(cmd, ch);
  endtask

  task key(logic [7:0] ch);
    send(CMD_KEY, ch);
  endtask

  task drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);   // settle time past the last strobe
  endtask

  // Register write; only called while the block is idle.
  task write_reg(reg_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.set_reg(idx, val);
    if (idx == REG_INTR) cur_intr = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly line editing traffic, some reads, a little noise.
  task random_item();
    int p;
    p = $urandom_range(99);
    if      (p < 45) key(8'($urandom_range(8'h21, 8'h7E)));
    else if (p < 53) key(ChSpace);
    else if (p < 58) key(($urandom_range(1)) ? ChDel : ChBs);
    else if (p < 63) key(($urandom_range(1)) ? ChNl : ChCr);
    else if (p < 65) key(ChEof);
    else if (p < 67) key(ChKillWord);
    else if (p < 68) key(ChKillLine);
    else if (p < 70) key(cur_intr);
    else if (p < 86) send(CMD_READ, 8'($urandom));
    else if (p < 87) send(CMD_FLUSH, 8'($urandom));
    else if (p < 88) send(CMD_NOP, 8'($urandom));
    else             key(8'($urandom));
  endtask

  initial begin
    logic [7:0] intr_pick[8];
    bit         cooked_pick[8];
    intr_pick   = '{8'hFF, 8'h00, 8'h03, 8'h7F, 8'h0D, 8'h61, 8'h04, 8'h03};
    cooked_pick = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, cooked, echo, signals, CR to NL.
    key(8'h20);              // lowest printable
    key(8'h7E);              // highest printable
    key(ChSpace);
    key(8'h61);
    key(ChKillWord);         // last word only; the space before it stays
    key(ChKillWord);
    key(ChBs);
    key(ChDel);              // erase on empty line: no echo
    key(8'h62);
    key(ChCr);               // CR becomes Enter
    key(ChEof);              // EOF on empty line
    key(8'h63);
    key(ChEof);              // EOF queues the line without terminator
    key(8'h64);
    key(ChKillLine);
    key(8'h65);
    key(8'h03);              // interrupt
    key(8'h01);              // other control byte
    key(8'h80);
    key(8'hFF);
    send(CMD_READ, 8'h00);
    send(CMD_READ, 8'hFF);
    send(CMD_NOP, 8'h5A);
    send(CMD_FLUSH, 8'h00);
    send(CMD_READ, 8'h00);   // read on empty
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_COOKED, {7'($urandom), cooked_pick[ph]});
      write_reg(REG_ECHO, (ph == 5) ? 8'h00 : 8'($urandom_range(255) | (ph < 4)));
      write_reg(REG_SIGNAL, (ph == 6) ? 8'hFE : 8'($urandom));
      write_reg(REG_CRNL, (ph == 7) ? 8'h00 : 8'($urandom));
      write_reg(REG_INTR, intr_pick[ph]);
      steady = (ph == 2);
      if (ph == 0) begin
        // raw: overfill the key ring, then drain part of it
        for (int i = 0; i < 560; i++) key(8'($urandom));
        for (int i = 0; i < 60; i++) send(CMD_READ, 8'($urandom));
      end
      if (ph == 1) begin
        // overlong line, then commit it
        for (int i = 0; i < 262; i++) key(8'($urandom_range(8'h20, 8'h7E)));
        key(ChBs);
        key(8'h41);
        key(8'h42);
        key(ChNl);
      end
      for (int i = 0; i < 100; i++) begin
        if (ph == 4 && i == 60) begin
          // hold off until every outstanding result is back
          @(negedge clk_i);
          start <= 1'b0;
          while (sb.pending() > 0) @(posedge clk_i);
        end
        random_item();
      end
      drain();
    end

    drain();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/tld_pkg.sv
hdl/tld_ctrl.sv
hdl/tld_datapath.sv
hdl/tty_line_discipline.sv
tb/tb_tty_line_discipline.sv
